FILE: design/prre_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the page replacement engine.
// Depends on nothing; every other design file imports it.
package prre_pkg;

    localparam int PROG_W      = 4;
    localparam int PAGE_W      = 10;
    localparam int ADDR_W      = 20;
    localparam int SHIFT_W     = 4;
    localparam int POLICY_W    = 2;
    localparam int FAULT_W     = 32;
    localparam int IDX_MAX_W   = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int OUT_FRAME_W = 4;

    typedef enum logic [1:0] {
        STAT_HIT     = 2'd0,
        STAT_DEMAND  = 2'd1,
        STAT_PREPAGE = 2'd2,
        STAT_RANGE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        POL_LRU   = 2'd0,
        POL_FIFO  = 2'd1,
        POL_CLOCK = 2'd2
    } policy_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY  = 2'd0,
        CFG_PREPAGE = 2'd1,
        CFG_SHIFT   = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        TBL_NOP,
        TBL_LOAD,
        TBL_REPLACE,
        TBL_HIT,
        TBL_CLEAR_USE
    } tbl_op_t;

    typedef struct packed {
        tbl_op_t               op;
        logic [IDX_MAX_W-1:0]  idx;
        logic [PROG_W-1:0]     prog;
        logic [PAGE_W-1:0]     page;
    } tbl_cmd_t;

    typedef struct packed {
        logic                  hit;
        logic [IDX_MAX_W-1:0]  hit_idx;
        logic                  free_any;
        logic [IDX_MAX_W-1:0]  free_idx;
    } tbl_stat_t;

endpackage

FILE: design/prre_table.sv
`timescale 1ns / 1ps
// Frame table: owner, page, recency rank and use bit of every frame,
// with parallel tag match and first-free search. Depends on prre_pkg.
module prre_table import prre_pkg::*; #(
    parameter int FRAMES = 16,
    localparam int FW = $clog2(FRAMES)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [PROG_W-1:0]  key_prog,
    input  logic [PAGE_W-1:0]  key_page,
    input  tbl_cmd_t           cmd,
    input  logic [FW-1:0]      rd_idx,
    output tbl_stat_t          stat,
    output logic [FW-1:0]      rd_rank,
    output logic               rd_use,
    output logic [PROG_W-1:0]  rd_owner,
    output logic [PAGE_W-1:0]  rd_page
);

    logic              valid_reg [FRAMES];
    logic              valid_next[FRAMES];
    logic [PROG_W-1:0] owner_reg [FRAMES];
    logic [PROG_W-1:0] owner_next[FRAMES];
    logic [PAGE_W-1:0] page_reg  [FRAMES];
    logic [PAGE_W-1:0] page_next [FRAMES];
    logic [FW-1:0]     rank_reg  [FRAMES];
    logic [FW-1:0]     rank_next [FRAMES];
    logic              use_reg   [FRAMES];
    logic              use_next  [FRAMES];
    logic [FW:0]       count_reg;
    logic [FW:0]       count_next;
    logic [FW-1:0]     f;
    logic [FW-1:0]     r;

    assign rd_rank  = rank_reg[rd_idx];
    assign rd_use   = use_reg[rd_idx];
    assign rd_owner = owner_reg[rd_idx];
    assign rd_page  = page_reg[rd_idx];

    // Lowest matching frame and lowest free frame.
    always_comb begin
        stat = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (valid_reg[i] && owner_reg[i] == key_prog && page_reg[i] == key_page) begin
                stat.hit     = 1'b1;
                stat.hit_idx = IDX_MAX_W'(i);
            end
            if (!valid_reg[i]) begin
                stat.free_any = 1'b1;
                stat.free_idx = IDX_MAX_W'(i);
            end
        end
    end

    always_comb begin
        f = cmd.idx[FW-1:0];
        r = rank_reg[f];
        count_next = count_reg;
        if (cmd.op == TBL_LOAD) begin
            count_next = count_reg + 1'b1;
        end
        for (int i = 0; i < FRAMES; i++) begin
            valid_next[i] = valid_reg[i];
            owner_next[i] = owner_reg[i];
            page_next[i]  = page_reg[i];
            rank_next[i]  = rank_reg[i];
            use_next[i]   = use_reg[i];
            case (cmd.op)
                TBL_LOAD: begin
                    if (FW'(i) == f) begin
                        valid_next[i] = 1'b1;
                        owner_next[i] = cmd.prog;
                        page_next[i]  = cmd.page;
                        rank_next[i]  = count_reg[FW-1:0];
                        use_next[i]   = 1'b1;
                    end
                end
                TBL_REPLACE, TBL_HIT: begin
                    // The touched frame becomes most recent; newer ones slide down.
                    if (FW'(i) == f) begin
                        rank_next[i] = FW'(count_reg - 1'b1);
                        use_next[i]  = 1'b1;
                        if (cmd.op == TBL_REPLACE) begin
                            owner_next[i] = cmd.prog;
                            page_next[i]  = cmd.page;
                        end
                    end else if (valid_reg[i] && rank_reg[i] > r) begin
                        rank_next[i] = rank_reg[i] - 1'b1;
                    end
                end
                TBL_CLEAR_USE: begin
                    if (FW'(i) == f) begin
                        use_next[i] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < FRAMES; i++) begin
            owner_reg[i] <= owner_next[i];
            page_reg[i]  <= page_next[i];
            rank_reg[i]  <= rank_next[i];
        end
        if (!aresetn) begin
            count_reg <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                valid_reg[i] <= 1'b0;
                use_reg[i]   <= 1'b0;
            end
        end else begin
            count_reg <= count_next;
            for (int i = 0; i < FRAMES; i++) begin
                valid_reg[i] <= valid_next[i];
                use_reg[i]   <= use_next[i];
            end
        end
    end

endmodule

FILE: design/page_replacement_engine.sv
`timescale 1ns / 1ps
// Page replacement engine top level: access sequencer, victim scan and result register.
// Depends on prre_pkg and prre_table.
// A fault loads a free frame or evicts a victim chosen by FIFO, an LRU scan or a clock scan;
// a prepaged result follows the demand result.
// One access at a time: s_tready returns as the last result is registered, and the victim
// scan, one frame per cycle, sets the worst case.
// Synchronous active-low reset empties all frames, clears pointers and counter and restores default config.
module page_replacement_engine import prre_pkg::*; #(
    parameter int FRAMES            = 16,
    parameter int PROGRAMS          = 16,
    parameter int PAGES_PER_PROGRAM = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write port; no read-back.
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // Access input. tdata: program_id [3:0], byte_address [23:4], last_page [33:24].
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [39:0]            s_tdata,
    // Results. tdata: frame_index [3:0], page_number [13:4], evicted_valid [14],
    // evicted_program [18:15], evicted_page [28:19], fault_total [60:29].
    // tuser: status [1:0]. tlast: last result of the access.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [63:0]            m_tdata,
    output logic [1:0]             m_tuser,
    output logic                   m_tlast
);

    localparam int FW = $clog2(FRAMES);

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_PRE, S_LOAD, S_SCAN, S_REPL
    } state_t;

    state_t             state_reg, state_next;
    logic [POLICY_W-1:0] policy_reg, policy_next;
    logic               prep_reg, prep_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;

    logic [PROG_W-1:0]  prog_reg, prog_next;
    logic [ADDR_W-1:0]  page_reg, page_next;     // full shifted address
    logic [PAGE_W-1:0]  last_reg, last_next;
    logic [PAGE_W-1:0]  npage_reg, npage_next;   // following page for prepaging
    logic [PAGE_W-1:0]  tgt_reg, tgt_next;       // page being loaded
    logic               pre_reg, pre_next;
    logic               second_reg, second_next;
    logic [FW-1:0]      fifo_reg, fifo_next;
    logic [FW-1:0]      hand_reg, hand_next;
    logic [FW-1:0]      scan_reg, scan_next;
    logic [FW-1:0]      vic_reg, vic_next;
    logic [FW:0]        best_reg, best_next;
    logic [FAULT_W-1:0] fault_reg, fault_next;

    logic               ovalid_reg, ovalid_next;
    status_t            ostat_reg, ostat_next;
    logic [FW-1:0]      oframe_reg, oframe_next;
    logic [PAGE_W-1:0]  opage_reg, opage_next;
    logic               oev_reg, oev_next;
    logic [PROG_W-1:0]  oevprog_reg, oevprog_next;
    logic [PAGE_W-1:0]  oevpage_reg, oevpage_next;
    logic [FAULT_W-1:0] ofault_reg, ofault_next;
    logic               olast_reg, olast_next;

    logic [PAGE_W-1:0]  key_page;
    tbl_cmd_t           cmd;
    tbl_stat_t          stat;
    logic [FW-1:0]      rd_idx;
    logic [FW-1:0]      rd_rank;
    logic               rd_use;
    logic [PROG_W-1:0]  rd_owner;
    logic [PAGE_W-1:0]  rd_page;
    logic               out_free;
    logic               out_of_range;
    logic               lru_take;
    logic [FW-1:0]      scan_inc;

    prre_table #(.FRAMES(FRAMES)) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .key_prog (prog_reg),
        .key_page (key_page),
        .cmd      (cmd),
        .rd_idx   (rd_idx),
        .stat     (stat),
        .rd_rank  (rd_rank),
        .rd_use   (rd_use),
        .rd_owner (rd_owner),
        .rd_page  (rd_page)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !ovalid_reg || m_tready;

    // The lookup key follows the phase: demanded page, then following page, then target.
    assign key_page = (state_reg == S_LOOK) ? page_reg[PAGE_W-1:0] :
                      (state_reg == S_PRE)  ? npage_reg : tgt_reg;
    assign rd_idx   = (state_reg == S_REPL) ? vic_reg : scan_reg;

    assign out_of_range = (page_reg > ADDR_W'(last_reg))
                       || (32'(page_reg) >= PAGES_PER_PROGRAM)
                       || (32'(prog_reg) >= PROGRAMS);
    assign lru_take = ({1'b0, rd_rank} < best_reg);
    assign scan_inc = (32'(scan_reg) == FRAMES - 1) ? '0 : scan_reg + 1'b1;

    always_comb begin
        state_next   = state_reg;
        policy_next  = policy_reg;
        prep_next    = prep_reg;
        shift_next   = shift_reg;
        prog_next    = prog_reg;
        page_next    = page_reg;
        last_next    = last_reg;
        npage_next   = npage_reg;
        tgt_next     = tgt_reg;
        pre_next     = pre_reg;
        second_next  = second_reg;
        fifo_next    = fifo_reg;
        hand_next    = hand_reg;
        scan_next    = scan_reg;
        vic_next     = vic_reg;
        best_next    = best_reg;
        fault_next   = fault_reg;
        ovalid_next  = ovalid_reg && !m_tready;
        ostat_next   = ostat_reg;
        oframe_next  = oframe_reg;
        opage_next   = opage_reg;
        oev_next     = oev_reg;
        oevprog_next = oevprog_reg;
        oevpage_next = oevpage_reg;
        ofault_next  = ofault_reg;
        olast_next   = olast_reg;
        cmd          = '0;
        cmd.op       = TBL_NOP;
        cmd.prog     = prog_reg;
        cmd.page     = tgt_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_POLICY:  policy_next = cfg_wdata[POLICY_W-1:0];
                CFG_PREPAGE: prep_next   = cfg_wdata[0];
                CFG_SHIFT:   shift_next  = cfg_wdata[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    prog_next  = s_tdata[3:0];
                    page_next  = s_tdata[23:4] >> shift_reg;
                    last_next  = s_tdata[33:24];
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                // Range check and hit handling answer once the output register is free; a miss counts a fault.
                if (out_of_range || stat.hit) begin
                    if (out_free) begin
                        ovalid_next  = 1'b1;
                        ostat_next   = out_of_range ? STAT_RANGE : STAT_HIT;
                        oframe_next  = out_of_range ? '0 : stat.hit_idx[FW-1:0];
                        opage_next   = page_reg[PAGE_W-1:0];
                        oev_next     = 1'b0;
                        oevprog_next = '0;
                        oevpage_next = '0;
                        ofault_next  = fault_reg;
                        olast_next   = 1'b1;
                        if (!out_of_range) begin
                            cmd.op  = TBL_HIT;
                            cmd.idx = stat.hit_idx;
                        end
                        state_next = S_IDLE;
                    end
                end else begin
                    if (fault_reg != '1) begin
                        fault_next = fault_reg + 1'b1;
                    end
                    npage_next = (page_reg == ADDR_W'(last_reg)) ? '0
                               : page_reg[PAGE_W-1:0] + 1'b1;
                    state_next = S_PRE;
                end
            end
            S_PRE: begin
                pre_next    = prep_reg && !stat.hit && (npage_reg != page_reg[PAGE_W-1:0]);
                second_next = 1'b0;
                tgt_next    = page_reg[PAGE_W-1:0];
                state_next  = S_LOAD;
            end
            S_LOAD: begin
                if (stat.free_any) begin
                    if (out_free) begin
                        cmd.op       = TBL_LOAD;
                        cmd.idx      = stat.free_idx;
                        ovalid_next  = 1'b1;
                        ostat_next   = second_reg ? STAT_PREPAGE : STAT_DEMAND;
                        oframe_next  = stat.free_idx[FW-1:0];
                        opage_next   = tgt_reg;
                        oev_next     = 1'b0;
                        oevprog_next = '0;
                        oevpage_next = '0;
                        ofault_next  = fault_reg;
                        olast_next   = second_reg || !pre_reg;
                        if (pre_reg && !second_reg) begin
                            second_next = 1'b1;
                            tgt_next    = npage_reg;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end
                end else if (policy_reg == POL_FIFO) begin
                    vic_next   = fifo_reg;
                    fifo_next  = (32'(fifo_reg) == FRAMES - 1) ? '0 : fifo_reg + 1'b1;
                    state_next = S_REPL;
                end else if (policy_reg == POL_CLOCK) begin
                    scan_next  = hand_reg;
                    state_next = S_SCAN;
                end else begin
                    scan_next  = '0;
                    best_next  = '1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // One frame per cycle: clock hand step or running rank minimum.
                if (policy_reg == POL_CLOCK) begin
                    if (!rd_use) begin
                        vic_next   = scan_reg;
                        hand_next  = scan_inc;
                        state_next = S_REPL;
                    end else begin
                        cmd.op    = TBL_CLEAR_USE;
                        cmd.idx   = IDX_MAX_W'(scan_reg);
                        scan_next = scan_inc;
                    end
                end else begin
                    if (lru_take) begin
                        best_next = {1'b0, rd_rank};
                        vic_next  = scan_reg;
                    end
                    scan_next = scan_inc;
                    if (32'(scan_reg) == FRAMES - 1) begin
                        state_next = S_REPL;
                    end
                end
            end
            S_REPL: begin
                if (out_free) begin
                    cmd.op       = TBL_REPLACE;
                    cmd.idx      = IDX_MAX_W'(vic_reg);
                    ovalid_next  = 1'b1;
                    ostat_next   = second_reg ? STAT_PREPAGE : STAT_DEMAND;
                    oframe_next  = vic_reg;
                    opage_next   = tgt_reg;
                    oev_next     = 1'b1;
                    oevprog_next = rd_owner;
                    oevpage_next = rd_page;
                    ofault_next  = fault_reg;
                    olast_next   = second_reg || !pre_reg;
                    if (pre_reg && !second_reg) begin
                        second_next = 1'b1;
                        tgt_next    = npage_reg;
                        state_next  = S_LOAD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prog_reg    <= prog_next;
        page_reg    <= page_next;
        last_reg    <= last_next;
        npage_reg   <= npage_next;
        tgt_reg     <= tgt_next;
        scan_reg    <= scan_next;
        vic_reg     <= vic_next;
        best_reg    <= best_next;
        ostat_reg   <= ostat_next;
        oframe_reg  <= oframe_next;
        opage_reg   <= opage_next;
        oev_reg     <= oev_next;
        oevprog_reg <= oevprog_next;
        oevpage_reg <= oevpage_next;
        ofault_reg  <= ofault_next;
        olast_reg   <= olast_next;
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            policy_reg <= POL_LRU;
            prep_reg   <= 1'b0;
            shift_reg  <= SHIFT_W'(2);
            pre_reg    <= 1'b0;
            second_reg <= 1'b0;
            fifo_reg   <= '0;
            hand_reg   <= '0;
            fault_reg  <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            policy_reg <= policy_next;
            prep_reg   <= prep_next;
            shift_reg  <= shift_next;
            pre_reg    <= pre_next;
            second_reg <= second_next;
            fifo_reg   <= fifo_next;
            hand_reg   <= hand_next;
            fault_reg  <= fault_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = ostat_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {3'b000, ofault_reg, oevpage_reg, oevprog_reg, oev_reg,
                       opage_reg, OUT_FRAME_W'(oframe_reg)};

    // The fault count only moves upward between resets.
    a_fault_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> fault_reg >= $past(fault_reg))
        else $error("fault counter decreased");

    // An eviction is reported only on a loaded page.
    a_evict_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (ovalid_reg && oev_reg) |-> (ostat_reg == STAT_DEMAND || ostat_reg == STAT_PREPAGE))
        else $error("eviction reported on a hit or range error");

    // FIFO never needs a frame scan.
    a_no_fifo_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (policy_reg != POL_FIFO))
        else $error("victim scan entered under FIFO policy");

endmodule

FILE: tb/sv/tb_page_replacement_engine.sv
`timescale 1ns / 1ps
// Self-checking testbench for the page replacement engine: directed accesses, then random
// access streams under each replacement policy with varied handshake idling.
// Depends on prre_pkg and the page_replacement_engine RTL.
module tb_page_replacement_engine;
    import prre_pkg::*;

    localparam int NFRAMES     = 16;
    localparam int NPAGES      = 1024;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYC  = 80;

    typedef struct {
        status_t     status;
        logic [3:0]  frame;
        logic [9:0]  page;
        logic        evicted;
        logic [3:0]  ev_prog;
        logic [9:0]  ev_page;
        logic [31:0] faults;
        logic        last;
    } page_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Idling odds in percent for the sender and the receiver.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int stall_cycles = 0;

    page_result_t pending_results[$];

    // Shadow of the engine: configuration and frame table.
    logic [1:0]  pol;
    logic        prepage_en;
    logic [3:0]  shift_amt;
    logic        fr_valid [NFRAMES];
    logic [3:0]  fr_owner [NFRAMES];
    logic [9:0]  fr_page  [NFRAMES];
    int unsigned fr_rank  [NFRAMES];
    logic        fr_use   [NFRAMES];
    int unsigned fifo_ptr;
    int unsigned hand;
    logic [31:0] fault_cnt;

    // Per-program last page used by the random streams.
    logic [9:0] prog_last_page [4];

    page_replacement_engine u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Frame table shadow.
    // ------------------------------------------------------------------
    function automatic void queue_result(page_result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic int unsigned resident_count();
        int unsigned n = 0;
        for (int i = 0; i < NFRAMES; i++) if (fr_valid[i]) n++;
        return n;
    endfunction

    // Moves a valid frame to the most recently used rank.
    function automatic void make_most_recent(int f);
        int unsigned r = fr_rank[f];
        int unsigned nv = resident_count();
        for (int i = 0; i < NFRAMES; i++) begin
            if (i != f && fr_valid[i] && fr_rank[i] > r) fr_rank[i]--;
        end
        fr_rank[f] = (nv > 0) ? nv - 1 : 0;
    endfunction

    function automatic int frame_of(logic [3:0] prog, logic [9:0] page);
        for (int i = 0; i < NFRAMES; i++) begin
            if (fr_valid[i] && fr_owner[i] == prog && fr_page[i] == page) return i;
        end
        return -1;
    endfunction

    function automatic int choose_victim();
        int v = 0;
        int unsigned best = 32'hFFFF_FFFF;
        if (pol == POL_FIFO) begin
            v = fifo_ptr;
            fifo_ptr = (fifo_ptr + 1) % NFRAMES;
            return v;
        end
        if (pol == POL_CLOCK) begin
            // Sweep clears use bits until it lands on a clear one.
            v = hand;
            for (int n = 0; n < 2 * NFRAMES + 1; n++) begin
                if (!fr_use[v]) break;
                fr_use[v] = 1'b0;
                v = (v + 1) % NFRAMES;
            end
            hand = (v + 1) % NFRAMES;
            return v;
        end
        // LRU, and the unused policy code falls back to it.
        for (int i = 0; i < NFRAMES; i++) begin
            if (fr_valid[i] && fr_rank[i] < best) begin
                best = fr_rank[i];
                v = i;
            end
        end
        return v;
    endfunction

    function automatic void place_page(logic [3:0] prog, logic [9:0] page, status_t st,
                                       logic last);
        page_result_t r;
        int f = -1;
        for (int i = 0; i < NFRAMES; i++) begin
            if (!fr_valid[i]) begin
                f = i;
                break;
            end
        end
        r.status = st;
        r.page = page;
        r.faults = fault_cnt;
        r.last = last;
        if (f >= 0) begin
            fr_rank[f] = resident_count();
            fr_valid[f] = 1'b1;
            r.evicted = 1'b0;
            r.ev_prog = '0;
            r.ev_page = '0;
        end else begin
            f = choose_victim();
            r.evicted = 1'b1;
            r.ev_prog = fr_owner[f];
            r.ev_page = fr_page[f];
        end
        fr_owner[f] = prog;
        fr_page[f] = page;
        fr_use[f] = 1'b1;
        if (r.evicted) make_most_recent(f);
        r.frame = f[3:0];
        queue_result(r);
    endfunction

    // Works out the results that one accepted access must produce.
    function automatic void predict_access(logic [3:0] prog, logic [19:0] addr,
                                           logic [9:0] lastp);
        page_result_t r;
        logic [19:0] pg = addr >> shift_amt;
        logic [9:0] nxt;
        logic do_pre;
        int f;
        r.evicted = 1'b0;
        r.ev_prog = '0;
        r.ev_page = '0;
        r.last = 1'b1;
        r.page = pg[9:0];
        if (pg > lastp || pg >= NPAGES) begin
            r.status = STAT_RANGE;
            r.frame = '0;
            r.faults = fault_cnt;
            queue_result(r);
            return;
        end
        f = frame_of(prog, pg[9:0]);
        if (f >= 0) begin
            make_most_recent(f);
            fr_use[f] = 1'b1;
            r.status = STAT_HIT;
            r.frame = f[3:0];
            r.faults = fault_cnt;
            queue_result(r);
            return;
        end
        if (fault_cnt != 32'hFFFF_FFFF) fault_cnt++;
        nxt = (pg[9:0] == lastp) ? 10'd0 : pg[9:0] + 10'd1;
        do_pre = prepage_en && frame_of(prog, nxt) < 0 && nxt != pg[9:0];
        place_page(prog, pg[9:0], STAT_DEMAND, !do_pre);
        if (do_pre) place_page(prog, nxt, STAT_PREPAGE, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------
    // The write strobe drops for one cycle between writes.
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_POLICY:  pol = val[1:0];
            CFG_PREPAGE: prepage_en = val[0];
            CFG_SHIFT:   shift_amt = val;
            default: ;
        endcase
    endtask

    // Holds the access on the bus until the engine takes it, idling first at random.
    task automatic send_access(logic [3:0] prog, logic [19:0] addr, logic [9:0] lastp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, lastp, addr, prog};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_access(prog, addr, lastp);
    endtask

    // Lowers valid and waits until every predicted result has come back, plus
    // enough cycles for the engine to settle before any register write.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    // Reset configuration: LRU, demand only, four-byte pages.
    task automatic test_range_and_hits();
        send_access(4'd0, 20'd0, 10'd0);
        send_access(4'd0, 20'd3, 10'd0);
        send_access(4'd15, 20'hFFFFF, 10'd1023);
        send_access(4'd15, 20'd4092, 10'd1023);
        send_access(4'd3, 20'd8, 10'd1);
        send_access(4'd15, 20'd4095, 10'd1023);
        drain();
    endtask

    // Prepaging: wrap of the last page to page zero, a resident next page that is
    // skipped, and a one-page program whose next page is itself.
    task automatic test_prepaging();
        write_reg(CFG_PREPAGE, 4'd1);
        send_access(4'd2, 20'd20, 10'd5);
        send_access(4'd2, 20'd16, 10'd5);
        send_access(4'd1, 20'd0, 10'd0);
        send_access(4'd2, 20'd0, 10'd5);
        drain();
    endtask

    // Overfills the table so that the chosen policy has to evict; the sequence runs it
    // under FIFO, clock and the unused policy code, with shifts of 0, 12 and 2.
    task automatic test_eviction(logic [1:0] policy, logic [3:0] shift);
        write_reg(CFG_POLICY, {2'b00, policy});
        write_reg(CFG_SHIFT, shift);
        write_reg(CFG_PREPAGE, 4'd0);
        for (int i = 0; i < 24; i++) begin
            send_access(4'd9, 20'(((i * 7) % 18) << shift), 10'd17);
        end
        drain();
    endtask

    // Random stream with a small working set so that hits, faults and
    // evictions all occur often; one access in ten is unconstrained noise.
    task automatic test_random_stream(logic [1:0] policy, logic prepage, logic [3:0] shift,
                                      int sidle, int rstall, int count);
        int unsigned maxpage;
        logic [3:0] prog;
        logic [9:0] pg;
        logic [19:0] addr;
        write_reg(CFG_POLICY, {2'b00, policy});
        write_reg(CFG_PREPAGE, {3'b000, prepage});
        write_reg(CFG_SHIFT, shift);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        maxpage = 20'hFFFFF >> shift;
        if (maxpage > NPAGES - 1) maxpage = NPAGES - 1;
        for (int p = 0; p < 4; p++) begin
            prog_last_page[p] = 10'($urandom_range(12, 1) < maxpage ?
                                    $urandom_range(12, 1) : maxpage);
        end
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) == 0) begin
                send_access(4'($urandom), 20'($urandom), 10'($urandom));
            end else begin
                prog = 4'($urandom_range(3));
                pg = 10'($urandom_range(prog_last_page[prog[1:0]]));
                addr = 20'((32'(pg) << shift) | ($urandom & ((32'd1 << shift) - 1)));
                send_access(prog, addr, prog_last_page[prog[1:0]]);
            end
            // Now and then the sender holds off until the engine has caught up.
            if ($urandom_range(59) == 0) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_results.size() != 0) @(posedge aclk);
            end
        end
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Result checking.
    // ------------------------------------------------------------------
    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        page_result_t r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no access outstanding");
                error_count++;
            end else begin
                r = pending_results.pop_front();
                check_field("status", r.status, m_tuser);
                check_field("frame_index", r.frame, m_tdata[3:0]);
                check_field("page_number", r.page, m_tdata[13:4]);
                check_field("evicted_valid", r.evicted, m_tdata[14]);
                check_field("evicted_program", r.ev_prog, m_tdata[18:15]);
                check_field("evicted_page", r.ev_page, m_tdata[28:19]);
                check_field("fault_total", r.faults, m_tdata[60:29]);
                check_field("last_of_run", r.last, m_tlast);
            end
        end
    end

    // Watchdog: the run ends if no transfer happens on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence.
    // ------------------------------------------------------------------
    initial begin
        pol = POL_LRU;
        prepage_en = 1'b0;
        shift_amt = 4'd2;
        fifo_ptr = 0;
        hand = 0;
        fault_cnt = '0;
        for (int i = 0; i < NFRAMES; i++) begin
            fr_valid[i] = 1'b0;
            fr_owner[i] = '0;
            fr_page[i] = '0;
            fr_rank[i] = 0;
            fr_use[i] = 1'b0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_range_and_hits();
        test_prepaging();
        test_eviction(POL_FIFO, 4'd0);
        test_eviction(POL_CLOCK, 4'd12);
        test_eviction(2'd3, 4'd2);

        test_random_stream(POL_LRU,   1'b0, 4'd2,  0,  0,  100);
        test_random_stream(POL_FIFO,  1'b1, 4'd0,  83, 0,  100);
        test_random_stream(POL_CLOCK, 1'b0, 4'd12, 0,  83, 100);
        test_random_stream(2'd3,      1'b1, 4'd5,  17, 17, 100);
        test_random_stream(POL_CLOCK, 1'b1, 4'd2,  0,  0,  100);
        test_random_stream(POL_FIFO,  1'b0, 4'd12, 17, 17, 100);
        test_random_stream(POL_LRU,   1'b1, 4'd0,  83, 0,  100);
        test_random_stream(POL_CLOCK, 1'b1, 4'd7,  0,  83, 100);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
